[rtl/abb_pkg.sv]
// abb_pkg: shared types, codes and helpers for the alpha blend blitter
// no dependencies; imported by alpha_blend_blitter
package abb_pkg;

    // input opcodes
    localparam logic [1:0] OP_FILL      = 2'd0;
    localparam logic [1:0] OP_COMPOSITE = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd4;

    // register reset values
    localparam logic [31:0] BG_RESET     = 32'hFF1A1A2E;
    localparam logic [8:0]  WIDTH_RESET  = 9'd256;
    localparam logic [8:0]  HEIGHT_RESET = 9'd256;
    localparam logic [8:0]  PITCH_RESET  = 9'd256;

    // pixel format
    localparam int          ALPHA_SHIFT  = 24;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;

    // width of y * pitch + x before wrapping into the store
    localparam int SUM_W = 19;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_MOD,
        ST_ACCESS,
        ST_RDWAIT,
        ST_BLEND,
        ST_DONE
    } abb_state_t;

    // what an item does to the store
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_WRITE,
        ACT_BLEND,
        ACT_READ
    } abb_act_t;

    // floor(n / 255) for n up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] n);
        logic [16:0] t;
        t = {1'b0, n} + 17'd1 + 17'(n[15:8]);
        return t[15:8];
    endfunction

endpackage

[rtl/alpha_blend_blitter.sv]
// alpha_blend_blitter: framebuffer of ARGB pixels with fill, composite and read-back
// depends on abb_pkg
//
// channel   | signals                                         | direction
// ----------+-------------------------------------------------+----------
// pixel     | pixel_valid, pixel_stall, opcode .. surface_shown| request in
// result    | result_valid, result_stall, read_value, wrote,  | request out
//           | clipped                                         |
// cfg       | cfg_valid, cfg_ready, cfg_index, cfg_data       | write in
//
// one request is in flight at a time; the address state goes straight to done when
//   nothing touches the store, and through access for a write, access and read wait for
//   a read, or access, read wait and blend for a blend; done loads the result and then
//   idle takes the next request, as set by the single-port frame memory and its registered read
// when MAX_WIDTH * MAX_HEIGHT is not a power of two, the address wrap adds a mod state
//   with one conditional subtract per step (SUM_W - bit length of depth + 1 steps)
//   to every request that touches the store
// reset clears control state and loads register defaults; the store is not cleared
// a result waiting on result_stall does not block acceptance of the next request
module alpha_blend_blitter #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          pixel_valid,
    output logic                          pixel_stall,
    input  logic [1:0]                    opcode,
    input  logic signed [11:0]            origin_x,
    input  logic signed [11:0]            origin_y,
    input  logic [11:0]                   local_x,
    input  logic [11:0]                   local_y,
    input  logic [31:0]                   source_pixel,
    input  logic                          surface_shown,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [31:0]                   read_value,
    output logic                          wrote,
    output logic                          clipped,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [abb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    import abb_pkg::*;

    // store geometry
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam bit DEPTH_POW2 = ((DEPTH & (DEPTH - 1)) == 0);
    localparam int DEPTH_BITS = $clog2(DEPTH + 1);
    // first shift of the wrap sequence: depth << MOD_TOP already covers any sum
    localparam int MOD_TOP    = (SUM_W > DEPTH_BITS) ? SUM_W - DEPTH_BITS : 0;
    localparam int MCW        = (MOD_TOP > 0) ? $clog2(MOD_TOP + 1) : 1;
    localparam int CMP_W      = SUM_W + DEPTH_BITS;

    // configuration registers
    logic [31:0] background_color_reg;
    logic [8:0]  output_width_reg;
    logic [8:0]  output_height_reg;
    logic [8:0]  row_pitch_reg;
    logic        output_enabled_reg;

    // control
    abb_state_t  state_reg, state_next;
    logic        result_valid_reg;

    // request fields
    logic [1:0]  opcode_reg;
    logic [11:0] origin_x_reg;
    logic [11:0] origin_y_reg;
    logic [11:0] local_x_reg;
    logic [11:0] local_y_reg;
    logic [31:0] source_reg;
    logic        shown_reg;

    // per-request working state
    abb_act_t       act_reg;
    logic           clip_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [MCW-1:0] mod_cnt_reg;
    logic [31:0]    wdata_reg;
    logic [31:0]    res_value_reg;
    logic [15:0]    prod_s_reg [3];
    logic [15:0]    prod_d_reg [3];

    // result register
    logic [31:0] read_value_reg;
    logic        wrote_reg;
    logic        clipped_reg;

    // frame memory
    logic [31:0] frame_mem [DEPTH];
    logic [31:0] rd_data_reg;
    logic        mem_we;
    logic        mem_re;
    logic [AW-1:0] mem_addr;
    logic [31:0] mem_wdata;

    logic        accept;
    logic        res_load;

    // ------------------------------------------------------------------
    // configuration port: always ready, writes beyond the list are dropped
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            background_color_reg <= BG_RESET;
            output_width_reg     <= WIDTH_RESET;
            output_height_reg    <= HEIGHT_RESET;
            row_pitch_reg        <= PITCH_RESET;
            output_enabled_reg   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BACKGROUND: background_color_reg <= cfg_data;
                REG_WIDTH:      output_width_reg     <= cfg_data[8:0];
                REG_HEIGHT:     output_height_reg    <= cfg_data[8:0];
                REG_PITCH:      row_pitch_reg        <= cfg_data[8:0];
                REG_ENABLE:     output_enabled_reg   <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // destination decode, done in the address state
    // ------------------------------------------------------------------
    logic signed [13:0] dst_x;
    logic signed [13:0] dst_y;
    logic               dst_inside;
    logic [7:0]         src_alpha;
    logic [17:0]        row_base;
    logic [SUM_W-1:0]   sum_calc;
    abb_act_t           act_calc;
    logic               clip_calc;

    assign src_alpha = source_reg[ALPHA_SHIFT +: 8];

    always_comb
    begin
        // fill and read use the local coordinate as the output coordinate
        if (opcode_reg == OP_COMPOSITE)
        begin
            dst_x = 14'(signed'(origin_x_reg)) + signed'({2'b00, local_x_reg});
            dst_y = 14'(signed'(origin_y_reg)) + signed'({2'b00, local_y_reg});
        end
        else
        begin
            dst_x = signed'({2'b00, local_x_reg});
            dst_y = signed'({2'b00, local_y_reg});
        end
    end

    assign dst_inside = !dst_x[13] && !dst_y[13]
                     && (dst_x[12:0] < {4'b0, output_width_reg})
                     && (dst_y[12:0] < {4'b0, output_height_reg});

    // only used when inside, so both coordinates fit in 9 bits
    assign row_base = dst_y[8:0] * row_pitch_reg;
    assign sum_calc = SUM_W'(row_base) + SUM_W'(dst_x[8:0]);

    always_comb
    begin
        act_calc  = ACT_NONE;
        clip_calc = 1'b0;
        case (opcode_reg)
            OP_FILL:
            begin
                if (!dst_inside)
                    clip_calc = 1'b1;
                else if (output_enabled_reg)
                    act_calc = ACT_WRITE;
            end
            OP_COMPOSITE:
            begin
                // hidden surface reports nothing at all
                if (shown_reg)
                begin
                    if (!dst_inside)
                        clip_calc = 1'b1;
                    else if (output_enabled_reg && src_alpha == ALPHA_OPAQUE)
                        act_calc = ACT_WRITE;
                    else if (output_enabled_reg && src_alpha != ALPHA_CLEAR)
                        act_calc = ACT_BLEND;
                end
            end
            OP_READ:
            begin
                if (!dst_inside)
                    clip_calc = 1'b1;
                else
                    act_calc = ACT_READ;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // address wrap: conditional subtract of depth << k, k counting down
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] depth_shifted;
    logic             sub_ok;

    assign depth_shifted = CMP_W'(DEPTH) << mod_cnt_reg;
    assign sub_ok        = (CMP_W'(sum_reg) >= depth_shifted);

    // ------------------------------------------------------------------
    // blend datapath: products registered, then divide and sum
    // ------------------------------------------------------------------
    logic [7:0]  inv_alpha;
    logic [7:0]  blend_ch [3];
    logic [31:0] blend_pixel;

    assign inv_alpha = ALPHA_OPAQUE - src_alpha;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            blend_ch[i] = div255(prod_s_reg[i]) + div255(prod_d_reg[i]);
    end

    assign blend_pixel = {ALPHA_OPAQUE, blend_ch[2], blend_ch[1], blend_ch[0]};

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pixel_valid)
                    state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                if (act_calc == ACT_NONE)
                    state_next = ST_DONE;
                else if (DEPTH_POW2)
                    state_next = ST_ACCESS;
                else
                    state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (mod_cnt_reg == '0)
                    state_next = ST_ACCESS;
            end
            ST_ACCESS:
            begin
                if (act_reg == ACT_WRITE)
                    state_next = ST_DONE;
                else
                    state_next = ST_RDWAIT;
            end
            ST_RDWAIT:
            begin
                if (act_reg == ACT_BLEND)
                    state_next = ST_BLEND;
                else
                    state_next = ST_DONE;
            end
            ST_BLEND:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pixel_stall = 1'b1;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_wdata   = wdata_reg;
        res_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                pixel_stall = 1'b0;
            ST_ACCESS:
            begin
                if (act_reg == ACT_WRITE)
                    mem_we = 1'b1;
                else
                    mem_re = 1'b1;
            end
            ST_BLEND:
            begin
                mem_we    = 1'b1;
                mem_wdata = blend_pixel;
            end
            ST_DONE:
                res_load = !result_valid_reg || !result_stall;
            default: ;
        endcase
    end

    assign accept   = pixel_valid && !pixel_stall;
    // after the wrap the sum is below depth; for a power-of-two depth truncation wraps it
    assign mem_addr = AW'(sum_reg);

    // ------------------------------------------------------------------
    // request datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg   <= opcode;
            origin_x_reg <= origin_x;
            origin_y_reg <= origin_y;
            local_x_reg  <= local_x;
            local_y_reg  <= local_y;
            source_reg   <= source_pixel;
            shown_reg    <= surface_shown;
        end

        if (state_reg == ST_ADDR)
        begin
            act_reg       <= act_calc;
            clip_reg      <= clip_calc;
            sum_reg       <= sum_calc;
            mod_cnt_reg   <= MCW'(MOD_TOP);
            wdata_reg     <= (opcode_reg == OP_FILL) ? background_color_reg : source_reg;
            res_value_reg <= '0;
        end

        if (state_reg == ST_MOD)
        begin
            if (sub_ok)
                sum_reg <= sum_reg - depth_shifted[SUM_W-1:0];
            if (mod_cnt_reg != '0)
                mod_cnt_reg <= mod_cnt_reg - MCW'(1);
        end

        if (state_reg == ST_RDWAIT)
        begin
            if (act_reg == ACT_READ)
                res_value_reg <= rd_data_reg;
            for (int i = 0; i < 3; i++)
            begin
                prod_s_reg[i] <= source_reg[8*i +: 8] * src_alpha;
                prod_d_reg[i] <= rd_data_reg[8*i +: 8] * inv_alpha;
            end
        end
    end

    // ------------------------------------------------------------------
    // frame memory, registered read
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= frame_mem[mem_addr];
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (res_load)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            read_value_reg <= res_value_reg;
            wrote_reg      <= (act_reg == ACT_WRITE) || (act_reg == ACT_BLEND);
            clipped_reg    <= clip_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign read_value   = read_value_reg;
    assign wrote        = wrote_reg;
    assign clipped      = clipped_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // one request in flight: the next cycle after acceptance is stalled
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pixel_stall)
        else $error("request accepted while another is in flight");

    // a clipped destination never writes
    a_clip_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && wrote |-> !clipped)
        else $error("result reports both write and clip");

    // only an unclipped read returns data
    a_read_only_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (read_value != 32'd0) |-> !wrote && !clipped)
        else $error("read data on a non-read result");

    // store writes need the output enabled
    a_write_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> output_enabled_reg)
        else $error("frame store written while output disabled");

endmodule

[dv/alpha_blend_blitter_tb.sv]
`timescale 1ns / 100ps
// testbench for alpha_blend_blitter: fill, composite and read-back requests against
// a cycle-free shadow of the framebuffer, with random idling on both channels
// depends on abb_pkg and alpha_blend_blitter
module testbench;

    import abb_pkg::*;

    // opcode 3 has no name in the package; the block treats it as a no-op
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int FB_WORDS       = 256 * 256;
    localparam int LONG_HOLD_AT   = 150;   // requests sent before the long result hold
    localparam int LONG_HOLD_LEN  = 60;    // cycles the result side holds off
    localparam int SETTLE_CYCLES  = 8;     // margin for the slowest request to finish

    // one pixel request, in port order
    typedef struct packed {
        logic [1:0]         op;
        logic signed [11:0] org_x;
        logic signed [11:0] org_y;
        logic [11:0]        loc_x;
        logic [11:0]        loc_y;
        logic [31:0]        argb;
        logic               shown;
    } pixel_req_t;

    // one result, in port order
    typedef struct packed {
        logic [31:0] value;
        logic        wrote;
        logic        clipped;
    } pixel_result_t;

    // register file as the block sees it
    typedef struct packed {
        logic [31:0] bg;
        logic [8:0]  width;
        logic [8:0]  height;
        logic [8:0]  pitch;
        logic        enable;
    } fb_regs_t;

    localparam fb_regs_t REGS_AT_RESET = {BG_RESET, WIDTH_RESET, HEIGHT_RESET, PITCH_RESET, 1'b1};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               pixel_valid   = 1'b0;
    logic               pixel_stall;
    logic [1:0]         opcode        = '0;
    logic signed [11:0] origin_x      = '0;
    logic signed [11:0] origin_y      = '0;
    logic [11:0]        local_x       = '0;
    logic [11:0]        local_y       = '0;
    logic [31:0]        source_pixel  = '0;
    logic               surface_shown = 1'b0;

    logic               result_valid;
    logic               result_stall  = 1'b0;
    logic [31:0]        read_value;
    logic               wrote;
    logic               clipped;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    alpha_blend_blitter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .opcode        (opcode),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .local_x       (local_x),
        .local_y       (local_y),
        .source_pixel  (source_pixel),
        .surface_shown (surface_shown),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .read_value    (read_value),
        .wrote         (wrote),
        .clipped       (clipped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // shadow state, updated in request order as the block accepts them
    fb_regs_t      shadow_regs;
    logic [31:0]   shadow_fb [0:FB_WORDS-1];
    pixel_result_t framebuffer_replies [$];

    // stimulus planning state: settings in force and which words hold a written pixel
    fb_regs_t      plan_regs = REGS_AT_RESET;
    bit            plan_filled [0:FB_WORDS-1];
    pixel_req_t    queued_pixel_reqs [$];

    int idle_pct    = 0;
    int pixels_sent = 0;
    int mismatches  = 0;
    int send_left   = 0;
    int stall_left  = 0;
    bit long_hold_done = 1'b0;

    function automatic bit dest_inside(fb_regs_t r, int x, int y);
        return x >= 0 && y >= 0 && x < int'(r.width) && y < int'(r.height);
    endfunction

    // address wraps modulo the store depth; only used for inside destinations
    function automatic logic [15:0] store_word(fb_regs_t r, int x, int y);
        return 16'(y * int'(r.pitch) + x);
    endfunction

    function automatic logic [7:0] over_channel(logic [7:0] s, logic [7:0] d, logic [7:0] a);
        return 8'((int'(s) * int'(a)) / 255 + (int'(d) * (255 - int'(a))) / 255);
    endfunction

    // applies one request to the shadow framebuffer and returns its result
    function automatic pixel_result_t framebuffer_apply(pixel_req_t r);
        pixel_result_t res;
        int            x;
        int            y;
        logic [15:0]   a;
        logic [7:0]    alpha;
        logic [31:0]   d;
        res   = '0;
        alpha = r.argb[ALPHA_SHIFT +: 8];
        x     = int'(r.loc_x);
        y     = int'(r.loc_y);
        case (r.op)
            OP_FILL:
            begin
                if (!dest_inside(shadow_regs, x, y))
                    res.clipped = 1'b1;
                else if (shadow_regs.enable)
                begin
                    shadow_fb[store_word(shadow_regs, x, y)] = shadow_regs.bg;
                    res.wrote = 1'b1;
                end
            end
            OP_COMPOSITE:
            begin
                if (r.shown)
                begin
                    x = int'($signed(r.org_x)) + int'(r.loc_x);
                    y = int'($signed(r.org_y)) + int'(r.loc_y);
                    if (!dest_inside(shadow_regs, x, y))
                        res.clipped = 1'b1;
                    else if (shadow_regs.enable)
                    begin
                        a = store_word(shadow_regs, x, y);
                        if (alpha == ALPHA_OPAQUE)
                        begin
                            shadow_fb[a] = r.argb;
                            res.wrote = 1'b1;
                        end
                        else if (alpha != ALPHA_CLEAR)
                        begin
                            d = shadow_fb[a];
                            shadow_fb[a] = {ALPHA_OPAQUE,
                                            over_channel(r.argb[23:16], d[23:16], alpha),
                                            over_channel(r.argb[15:8], d[15:8], alpha),
                                            over_channel(r.argb[7:0], d[7:0], alpha)};
                            res.wrote = 1'b1;
                        end
                    end
                end
            end
            OP_READ:
            begin
                if (!dest_inside(shadow_regs, x, y))
                    res.clipped = 1'b1;
                else
                    res.value = shadow_fb[store_word(shadow_regs, x, y)];
            end
            default: ;
        endcase
        return res;
    endfunction

    // register shadow follows accepted writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shadow_regs <= REGS_AT_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BACKGROUND: shadow_regs.bg     <= cfg_data;
                REG_WIDTH:      shadow_regs.width  <= cfg_data[8:0];
                REG_HEIGHT:     shadow_regs.height <= cfg_data[8:0];
                REG_PITCH:      shadow_regs.pitch  <= cfg_data[8:0];
                REG_ENABLE:     shadow_regs.enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // request driver: predicts on acceptance, holds the payload while stalled,
    // and inserts random gaps at the current idle rate
    always @(posedge clk or negedge rst_n)
    begin : pixel_driver
        pixel_req_t r;
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            send_left   <= 0;
            pixels_sent <= 0;
        end
        else
        begin
            if (pixel_valid && !pixel_stall)
            begin
                r = {opcode, origin_x, origin_y, local_x, local_y, source_pixel, surface_shown};
                framebuffer_replies.push_back(framebuffer_apply(r));
                pixels_sent <= pixels_sent + 1;
            end
            if (!pixel_valid || !pixel_stall)
            begin
                if (send_left != 0)
                begin
                    send_left   <= send_left - 1;
                    pixel_valid <= 1'b0;
                end
                else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
                begin
                    send_left   <= $urandom_range(0, 6);
                    pixel_valid <= 1'b0;
                end
                else if (queued_pixel_reqs.size() != 0)
                begin
                    r = queued_pixel_reqs.pop_front();
                    {opcode, origin_x, origin_y, local_x, local_y, source_pixel, surface_shown} <= r;
                    pixel_valid <= 1'b1;
                end
                else
                    pixel_valid <= 1'b0;
            end
        end
    end

    // result side stalls: one long hold once enough requests went in, so the block
    // fills and pushes back on the sender, then random bursts at the current idle rate
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall   <= 1'b0;
            stall_left     <= 0;
            long_hold_done <= 1'b0;
        end
        else if (!long_hold_done && pixels_sent >= LONG_HOLD_AT)
        begin
            result_stall   <= 1'b1;
            stall_left     <= LONG_HOLD_LEN;
            long_hold_done <= 1'b1;
        end
        else if (stall_left > 1)
            stall_left <= stall_left - 1;
        else if (stall_left == 1)
        begin
            stall_left   <= 0;
            result_stall <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            result_stall <= 1'b1;
            stall_left   <= $urandom_range(1, 7);
        end
    end

    task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %h got %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // compares each accepted result with the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        pixel_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (framebuffer_replies.size() == 0)
            begin
                $display("%0t ns: result with no request outstanding, expected none got %h/%b/%b",
                         $time, read_value, wrote, clipped);
                mismatches++;
            end
            else
            begin
                want = framebuffer_replies.pop_front();
                check_field("read_value", want.value, read_value);
                check_field("wrote", 32'(want.wrote), 32'(wrote));
                check_field("clipped", 32'(want.clipped), 32'(clipped));
            end
        end
    end

    function automatic fb_regs_t fb_setting(logic [31:0] bg, int w, int h, int p, logic en);
        return {bg, 9'(w), 9'(h), 9'(p), en};
    endfunction

    function automatic pixel_req_t pix(logic [1:0] op, int ox, int oy, int lx, int ly,
                                       logic [31:0] argb, logic shown);
        return {op, 12'(ox), 12'(oy), 12'(lx), 12'(ly), argb, shown};
    endfunction

    // mostly a small corner where pixels get reused, sometimes the clip edge,
    // sometimes anywhere in the 12-bit range
    function automatic int pick_coord(int edge_at);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 8)
            return $urandom_range(0, 23);
        if (roll == 8)
            return (edge_at < 2) ? $urandom_range(0, 3) : $urandom_range(edge_at - 2, edge_at + 1);
        return $urandom_range(0, 4095);
    endfunction

    // local coordinate that reaches destination d with an origin inside 12 signed bits
    function automatic int local_for(int d);
        int lo;
        int hi;
        lo = (d > 2047) ? d - 2047 : 0;
        hi = (d + 2048 > 4095) ? 4095 : d + 2048;
        if ($urandom_range(0, 1) == 1)
        begin
            lo = (d - 8 > lo) ? d - 8 : lo;
            hi = (d + 8 < hi) ? d + 8 : hi;
        end
        return $urandom_range(lo, hi);
    endfunction

    function automatic pixel_req_t rand_pixel();
        pixel_req_t r;
        int         roll;
        int         dx;
        int         dy;
        int         pick;
        roll    = $urandom_range(0, 99);
        dx      = pick_coord(int'(plan_regs.width));
        dy      = pick_coord(int'(plan_regs.height));
        r       = pix(OP_FILL, 0, 0, dx, dy, $urandom(), 1'b1);
        // origin is ignored by fill and read, but give it some traffic anyway
        if ($urandom_range(0, 3) == 0)
        begin
            r.org_x = 12'($urandom());
            r.org_y = 12'($urandom());
        end
        if (roll < 30)
            r.op = OP_FILL;
        else if (roll < 55)
            r.op = OP_READ;
        else if (roll < 95)
        begin
            r.op    = OP_COMPOSITE;
            r.loc_x = 12'(local_for(dx));
            r.loc_y = 12'(local_for(dy));
            r.org_x = 12'(dx - int'(r.loc_x));
            r.org_y = 12'(dy - int'(r.loc_y));
            pick    = $urandom_range(0, 9);
            if (pick < 2)
                r.argb[ALPHA_SHIFT +: 8] = ALPHA_CLEAR;
            else if (pick < 4)
                r.argb[ALPHA_SHIFT +: 8] = ALPHA_OPAQUE;
            else
                r.argb[ALPHA_SHIFT +: 8] = 8'($urandom_range(1, 254));
            if (roll >= 91)
                r.shown = 1'b0;
        end
        else if (roll < 98)
            // fully random surface placement, mostly lands outside
            r = {OP_COMPOSITE, 24'($urandom()), 24'($urandom()), 32'($urandom()), 1'b1};
        else
            r.op = OP_UNUSED;
        return r;
    endfunction

    // queues a request, keeping it away from words that were never written:
    // a read of such a word becomes a fill, a blend onto one becomes a copy
    task automatic queue_pixel(input pixel_req_t r);
        int          x;
        int          y;
        bit          in_area;
        logic [15:0] a;
        x = int'(r.loc_x);
        y = int'(r.loc_y);
        if (r.op == OP_COMPOSITE)
        begin
            x = int'($signed(r.org_x)) + x;
            y = int'($signed(r.org_y)) + y;
        end
        in_area = dest_inside(plan_regs, x, y);
        a       = in_area ? store_word(plan_regs, x, y) : 16'd0;
        if (in_area && r.op == OP_READ && !plan_filled[a])
            r.op = OP_FILL;
        if (in_area && r.op == OP_COMPOSITE && r.shown && plan_regs.enable && !plan_filled[a]
            && r.argb[ALPHA_SHIFT +: 8] != ALPHA_CLEAR)
            r.argb[ALPHA_SHIFT +: 8] = ALPHA_OPAQUE;
        if (in_area && plan_regs.enable && (r.op == OP_FILL || (r.op == OP_COMPOSITE && r.shown
            && r.argb[ALPHA_SHIFT +: 8] != ALPHA_CLEAR)))
            plan_filled[a] = 1'b1;
        queued_pixel_reqs.push_back(r);
    endtask

    // sender holds back until every prediction has been answered, then lets the
    // block settle before anything touches its registers; the idle test is made
    // at the falling edge, after the driver has settled its queue and valid
    task automatic drain();
        while (queued_pixel_reqs.size() != 0 || pixel_valid || framebuffer_replies.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes all five registers back to back; upper data bits are junk on purpose
    task automatic apply_settings(input fb_regs_t s);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [31:0]          val [5];
        idx[0] = REG_BACKGROUND;  val[0] = s.bg;
        idx[1] = REG_WIDTH;       val[1] = {23'($urandom()), s.width};
        idx[2] = REG_HEIGHT;      val[2] = {23'($urandom()), s.height};
        idx[3] = REG_PITCH;       val[3] = {23'($urandom()), s.pitch};
        idx[4] = REG_ENABLE;      val[4] = {31'($urandom()), s.enable};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 5; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        plan_regs = s;
    endtask

    task automatic run_phase(input fb_regs_t s, input int count, input int pct);
        drain();
        apply_settings(s);
        idle_pct = pct;
        repeat (count) queue_pixel(rand_pixel());
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests at reset settings
        idle_pct = 30;
        queue_pixel(pix(OP_FILL, -2048, 2047, 0, 0, 32'h0, 1'b0));     // origin ignored
        queue_pixel(pix(OP_FILL, 0, 0, 255, 255, 32'h0, 1'b1));       // far corner
        queue_pixel(pix(OP_FILL, 0, 0, 256, 0, 32'h0, 1'b1));          // one past right edge
        queue_pixel(pix(OP_FILL, 0, 0, 0, 256, 32'h0, 1'b1));          // one past bottom edge
        queue_pixel(pix(OP_FILL, 0, 0, 4095, 4095, 32'h0, 1'b1));
        queue_pixel(pix(OP_READ, 0, 0, 0, 0, 32'h0, 1'b1));
        queue_pixel(pix(OP_READ, -1, -1, 255, 255, 32'hFFFF_FFFF, 1'b1));
        queue_pixel(pix(OP_READ, 0, 0, 256, 255, 32'h0, 1'b1));        // clipped read
        queue_pixel(pix(OP_READ, 0, 0, 4095, 0, 32'h0, 1'b1));
        queue_pixel(pix(OP_COMPOSITE, -5, -3, 5, 3, 32'hFF12_3456, 1'b1));  // opaque copy
        queue_pixel(pix(OP_COMPOSITE, 0, 0, 0, 0, 32'h00FF_FFFF, 1'b1));    // transparent
        queue_pixel(pix(OP_COMPOSITE, 0, 0, 0, 0, 32'h80FF_00FF, 1'b1));    // half blend
        queue_pixel(pix(OP_COMPOSITE, 0, 0, 0, 0, 32'h01FF_FFFF, 1'b1));    // faintest blend
        queue_pixel(pix(OP_COMPOSITE, 0, 0, 0, 0, 32'hFE00_0000, 1'b1));    // strongest blend
        queue_pixel(pix(OP_COMPOSITE, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b0));    // hidden surface
        queue_pixel(pix(OP_COMPOSITE, -2048, -2048, 0, 0, 32'hFF00_0000, 1'b1));
        queue_pixel(pix(OP_COMPOSITE, 2047, 2047, 4095, 4095, 32'hFF00_0000, 1'b1));
        queue_pixel(pix(OP_COMPOSITE, -1, -1, 0, 0, 32'hFF00_0000, 1'b1)); // just above-left
        queue_pixel(pix(OP_COMPOSITE, 0, 0, 255, 255, 32'h7FFF_FFFF, 1'b1));
        queue_pixel(pix(OP_UNUSED, 2047, -2048, 4095, 4095, 32'hFFFF_FFFF, 1'b1));
        queue_pixel(pix(OP_READ, 0, 0, 0, 0, 32'h0, 1'b1));
        queue_pixel(pix(OP_READ, 0, 0, 255, 255, 32'h0, 1'b1));

        // random phases; the long result hold falls in the second one
        run_phase(fb_setting($urandom(), 256, 256, 256, 1'b1), 85, 20);
        run_phase(fb_setting(32'h0000_0000, 20, 12, 20, 1'b1), 85, 50);
        run_phase(fb_setting(32'hFFFF_FFFF, 511, 511, 511, 1'b1), 85, 30);
        run_phase(fb_setting($urandom(), 0, 0, 256, 1'b1), 40, 20);       // nothing visible
        run_phase(fb_setting($urandom(), 256, 256, 1, 1'b0), 85, 40);     // writes suppressed
        run_phase(fb_setting($urandom(), 30, 30, 0, 1'b1), 85, 20);       // every row aliases
        run_phase(fb_setting($urandom(), 1, 1, 256, 1'b1), 60, 30);       // single pixel
        run_phase(fb_setting($urandom(), 256, 256, 256, 1'b1), 160, 0);   // no idling at the end
        drain();

        if (mismatches == 0 && framebuffer_replies.size() == 0)
            $display("alpha_blend_blitter: match");
        else
            $display("alpha_blend_blitter: mismatch");
        $finish;
    end

    initial
    begin
        #(4_000_000);
        $display("alpha_blend_blitter: mismatch");
        $finish;
    end

endmodule
